[sv/sqct_pkg.sv]
// Shared definitions for the sprite quad corner transform.
// Field widths, default parameter values, the stage advance struct and the
// quarter-wave sine generator used to build the trig ROM. No dependencies.
package sqct_pkg;

  localparam int ANGLE_BITS_DEF     = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  localparam int COORD_W = 16;
  localparam int SCALE_W = 16;
  localparam int OUT_W   = 24;

  // Pivot-relative offsets before scaling (rect - pivot spans 18 bits).
  localparam int OFS_W = 18;
  // Exact scaled offsets, Q.16.
  localparam int TX_W  = 34;
  // Rotated offsets after rounding to Q.4.
  localparam int ROT_W = TX_W - 8;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One advance enable per pipeline stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Product of two Q2.30 values, kept in Q2.30.
  function automatic bit [63:0] mul_q30(bit [63:0] a, bit [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Quarter-wave sine entry i of 2^(ab-2) steps, Q1.tf, rounded half up.
  // Evaluated only while the design elaborates. The Taylor terms alternate
  // in sign; term n is divided by (2n)(2n+1).
  function automatic logic [16:0] qsin(int unsigned i, int unsigned ab,
                                       int unsigned tf);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] pos;
    bit [63:0] neg;
    bit [63:0] s;
    x    = (64'(i) * 64'd1686629713) >> (ab - 2);
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    term = mul_q30(term, x2) / 64'd6;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd20;
    pos  = pos + term;
    term = mul_q30(term, x2) / 64'd42;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd72;
    pos  = pos + term;
    term = mul_q30(term, x2) / 64'd110;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd156;
    pos  = pos + term;
    term = mul_q30(term, x2) / 64'd210;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd272;
    pos  = pos + term;
    term = mul_q30(term, x2) / 64'd342;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd420;
    pos  = pos + term;
    term = mul_q30(term, x2) / 64'd506;
    neg  = neg + term;
    term = mul_q30(term, x2) / 64'd600;
    pos  = pos + term;
    s = pos - neg;
    s = (s + (64'd1 << (29 - tf))) >> (30 - tf);
    return s[16:0];
  endfunction

endpackage

[sv/sqct_sin_rom.sv]
// Quarter-wave sine ROM with two registered read ports.
// Contents are generated from sqct_pkg::qsin at elaboration.
module sqct_sin_rom #(
  parameter int ANGLE_BITS     = sqct_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = sqct_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [ANGLE_BITS-2:0]     addr_a,
  input  logic [ANGLE_BITS-2:0]     addr_b,
  output logic [TRIG_FRAC_BITS:0]   data_a,
  output logic [TRIG_FRAC_BITS:0]   data_b
);

  localparam int DEPTH = (1 << (ANGLE_BITS - 2)) + 1;

  logic [TRIG_FRAC_BITS:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [16:0] VAL = sqct_pkg::qsin(i, ANGLE_BITS, TRIG_FRAC_BITS);
    assign rom[i] = VAL[TRIG_FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

[sv/sqct_offset.sv]
// Front end: pivot-relative offsets, scale selection, trig lookup (stage 1)
// and the scaled offsets with signed sine and cosine (stage 2).
// Depends on sqct_pkg and sqct_sin_rom.
module sqct_offset #(
  parameter int ANGLE_BITS     = sqct_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = sqct_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  sqct_pkg::pipe_en_t                    en,
  input  logic signed [sqct_pkg::COORD_W-1:0]   pivot_x,
  input  logic signed [sqct_pkg::COORD_W-1:0]   pivot_y,
  input  logic        [sqct_pkg::COORD_W-1:0]   rect_w,
  input  logic        [sqct_pkg::COORD_W-1:0]   rect_h,
  input  logic        [ANGLE_BITS-1:0]          angle,
  input  logic signed [sqct_pkg::SCALE_W-1:0]   scale_h,
  input  logic signed [sqct_pkg::SCALE_W-1:0]   scale_v,
  output logic signed [sqct_pkg::TX_W-1:0]      tx [2],
  output logic signed [sqct_pkg::TX_W-1:0]      ty [2],
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_v,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_v
);

  localparam int AW = ANGLE_BITS - 1;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int OW = sqct_pkg::OFS_W;
  localparam int XW = sqct_pkg::TX_W;
  localparam logic [AW-1:0] QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  logic [AW-1:0] idx_ext;
  logic [AW-1:0] addr_c;
  logic [TRIG_FRAC_BITS:0] rom_s;
  logic [TRIG_FRAC_BITS:0] rom_c;
  logic signed [TW-1:0] ps;
  logic signed [TW-1:0] pc;
  logic signed [TW-1:0] sin_next;
  logic signed [TW-1:0] cos_next;

  // Stage 1 registers.
  logic signed [OW-1:0] ox0;
  logic signed [OW-1:0] ox1;
  logic signed [OW-1:0] oy0;
  logic signed [OW-1:0] oy1;
  logic signed [sqct_pkg::SCALE_W-1:0] sh;
  logic signed [sqct_pkg::SCALE_W-1:0] sv;
  logic [1:0] quad;

  assign idx_ext = {1'b0, angle[ANGLE_BITS-3:0]};
  assign addr_c  = QUARTER - idx_ext;

  sqct_sin_rom #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rom (
    .clk   (clk),
    .ce    (en.s1),
    .addr_a(idx_ext),
    .addr_b(addr_c),
    .data_a(rom_s),
    .data_b(rom_c)
  );

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ox0  <= -OW'(pivot_x);
      ox1  <= $signed(OW'(rect_w)) - OW'(pivot_x);
      oy0  <= -OW'(pivot_y);
      oy1  <= $signed(OW'(rect_h)) - OW'(pivot_y);
      sh   <= scale_h;
      sv   <= (scale_v == '0) ? scale_h : scale_v;
      quad <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  assign ps = $signed(TW'(rom_s));
  assign pc = $signed(TW'(rom_c));

  // Fold the quarter-wave values into the full circle.
  always_comb begin
    case (quad)
      QUAD_I: begin
        sin_next = ps;
        cos_next = pc;
      end
      QUAD_II: begin
        sin_next = pc;
        cos_next = -ps;
      end
      QUAD_III: begin
        sin_next = -ps;
        cos_next = -pc;
      end
      default: begin
        sin_next = -pc;
        cos_next = ps;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      tx[0] <= XW'(ox0) * XW'(sh);
      tx[1] <= XW'(ox1) * XW'(sh);
      ty[0] <= XW'(oy0) * XW'(sv);
      ty[1] <= XW'(oy1) * XW'(sv);
      sin_v <= sin_next;
      cos_v <= cos_next;
    end
  end

endmodule

[sv/sqct_rotate.sv]
// Rotation: eight exact products (stage 3), then per-corner sums rounded
// half up to Q.4 (stage 4). Depends on sqct_pkg.
module sqct_rotate #(
  parameter int TRIG_FRAC_BITS = sqct_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  sqct_pkg::pipe_en_t                  en,
  input  logic signed [sqct_pkg::TX_W-1:0]    tx [2],
  input  logic signed [sqct_pkg::TX_W-1:0]    ty [2],
  input  logic signed [TRIG_FRAC_BITS+1:0]    sin_v,
  input  logic signed [TRIG_FRAC_BITS+1:0]    cos_v,
  output logic signed [sqct_pkg::ROT_W-1:0]   rx [4],
  output logic signed [sqct_pkg::ROT_W-1:0]   ry [4]
);

  localparam int PW = sqct_pkg::TX_W + TRIG_FRAC_BITS + 2;
  localparam int SW = PW + 2;
  localparam int SH = 12 + TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (SH - 1);

  logic signed [PW-1:0] txc [2];
  logic signed [PW-1:0] txs [2];
  logic signed [PW-1:0] tyc [2];
  logic signed [PW-1:0] tys [2];

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int j = 0; j < 2; j++) begin
        txc[j] <= PW'(tx[j]) * PW'(cos_v);
        txs[j] <= PW'(tx[j]) * PW'(sin_v);
        tyc[j] <= PW'(ty[j]) * PW'(cos_v);
        tys[j] <= PW'(ty[j]) * PW'(sin_v);
      end
    end
  end

  // Corners run top-left, top-right, bottom-right, bottom-left.
  for (genvar k = 0; k < 4; k++) begin : g_corner
    localparam int XI = (k == 1 || k == 2) ? 1 : 0;
    localparam int YI = (k >= 2) ? 1 : 0;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;

    assign sum_x = SW'(txc[XI]) - SW'(tys[YI]) + HALF;
    assign sum_y = SW'(txs[XI]) + SW'(tyc[YI]) + HALF;

    always_ff @(posedge clk) begin
      if (en.s4) begin
        rx[k] <= $signed(sum_x[SW-1:SH]);
        ry[k] <= $signed(sum_y[SW-1:SH]);
      end
    end
  end

endmodule

[sv/sprite_quad_corner_transform_unit.sv]
// Top level of the sprite quad corner transform: handshake, stage valid
// bits, position delay line and the saturating output stage.
// Depends on sqct_pkg, sqct_offset and sqct_rotate.
//
// One sprite transfer in gives one transfer out holding the four screen
// corners (top-left, top-right, bottom-right, bottom-left) in signed Q20.4.
// The unit is a five-stage pipeline: offsets and the sine ROM read, scaling
// multiplies, rotation multiplies, rounding sums, and position add with
// saturation into the output register. It accepts one sprite every cycle
// while its input is not stalled, and a result is offered once it has passed
// through every stage. Each stage holds its own valid bit and advances
// whenever it is empty or the stage after it advances, so bubbles close up
// under a stall and the input is stalled only when every stage holds a
// sprite and the output is stalled. A vertical scale of zero selects the
// horizontal scale on both axes. The trig table is a ROM of
// 2^(ANGLE_BITS-2)+1 entries read on two ports per cycle while the first
// stage advances. Reset clears only the valid bits.
module sprite_quad_corner_transform_unit #(
  parameter int ANGLE_BITS     = sqct_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = sqct_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sprite_valid,
  output logic                                sprite_stall,
  input  logic signed [sqct_pkg::COORD_W-1:0] pos_x,
  input  logic signed [sqct_pkg::COORD_W-1:0] pos_y,
  input  logic signed [sqct_pkg::COORD_W-1:0] pivot_x,
  input  logic signed [sqct_pkg::COORD_W-1:0] pivot_y,
  input  logic        [sqct_pkg::COORD_W-1:0] rect_w,
  input  logic        [sqct_pkg::COORD_W-1:0] rect_h,
  input  logic        [ANGLE_BITS-1:0]        angle,
  input  logic signed [sqct_pkg::SCALE_W-1:0] scale_h,
  input  logic signed [sqct_pkg::SCALE_W-1:0] scale_v,
  output logic                                quad_valid,
  input  logic                                quad_stall,
  output logic signed [sqct_pkg::OUT_W-1:0]   c0_x,
  output logic signed [sqct_pkg::OUT_W-1:0]   c0_y,
  output logic signed [sqct_pkg::OUT_W-1:0]   c1_x,
  output logic signed [sqct_pkg::OUT_W-1:0]   c1_y,
  output logic signed [sqct_pkg::OUT_W-1:0]   c2_x,
  output logic signed [sqct_pkg::OUT_W-1:0]   c2_y,
  output logic signed [sqct_pkg::OUT_W-1:0]   c3_x,
  output logic signed [sqct_pkg::OUT_W-1:0]   c3_y
);

  localparam int RW = sqct_pkg::ROT_W;
  localparam int CW = sqct_pkg::COORD_W;
  localparam int OW = sqct_pkg::OUT_W;

  // Valid bit of stages one through five; bit 4 is the output register.
  logic [4:0] vld;
  sqct_pkg::pipe_en_t en;

  logic signed [sqct_pkg::TX_W-1:0]  tx [2];
  logic signed [sqct_pkg::TX_W-1:0]  ty [2];
  logic signed [TRIG_FRAC_BITS+1:0]  sin_v;
  logic signed [TRIG_FRAC_BITS+1:0]  cos_v;
  logic signed [RW-1:0]              rx [4];
  logic signed [RW-1:0]              ry [4];

  // The position rides along until the final add.
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  logic signed [OW-1:0] cx_next [4];
  logic signed [OW-1:0] cy_next [4];

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    en.s5 = !vld[4] || !quad_stall;
    en.s4 = !vld[3] || en.s5;
    en.s3 = !vld[2] || en.s4;
    en.s2 = !vld[1] || en.s3;
    en.s1 = !vld[0] || en.s2;
  end

  assign sprite_stall = !en.s1;
  assign quad_valid   = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= sprite_valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      px[0] <= pos_x;
      py[0] <= pos_y;
    end
    if (en.s2) begin
      px[1] <= px[0];
      py[1] <= py[0];
    end
    if (en.s3) begin
      px[2] <= px[1];
      py[2] <= py[1];
    end
    if (en.s4) begin
      px[3] <= px[2];
      py[3] <= py[2];
    end
  end

  sqct_offset #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_offset (
    .clk    (clk),
    .en     (en),
    .pivot_x(pivot_x),
    .pivot_y(pivot_y),
    .rect_w (rect_w),
    .rect_h (rect_h),
    .angle  (angle),
    .scale_h(scale_h),
    .scale_v(scale_v),
    .tx     (tx),
    .ty     (ty),
    .sin_v  (sin_v),
    .cos_v  (cos_v)
  );

  sqct_rotate #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rotate (
    .clk  (clk),
    .en   (en),
    .tx   (tx),
    .ty   (ty),
    .sin_v(sin_v),
    .cos_v(cos_v),
    .rx   (rx),
    .ry   (ry)
  );

  // Add the position and clamp each coordinate to the 24-bit range.
  for (genvar k = 0; k < 4; k++) begin : g_sat
    logic signed [RW:0] sx;
    logic signed [RW:0] sy;

    assign sx = (RW+1)'(rx[k]) + (RW+1)'(px[3]);
    assign sy = (RW+1)'(ry[k]) + (RW+1)'(py[3]);

    always_comb begin
      if (sx > (RW+1)'(sqct_pkg::OUT_MAX)) begin
        cx_next[k] = sqct_pkg::OUT_MAX;
      end else if (sx < (RW+1)'(sqct_pkg::OUT_MIN)) begin
        cx_next[k] = sqct_pkg::OUT_MIN;
      end else begin
        cx_next[k] = sx[OW-1:0];
      end
      if (sy > (RW+1)'(sqct_pkg::OUT_MAX)) begin
        cy_next[k] = sqct_pkg::OUT_MAX;
      end else if (sy < (RW+1)'(sqct_pkg::OUT_MIN)) begin
        cy_next[k] = sqct_pkg::OUT_MIN;
      end else begin
        cy_next[k] = sy[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      c0_x <= cx_next[0];
      c0_y <= cy_next[0];
      c1_x <= cx_next[1];
      c1_y <= cy_next[1];
      c2_x <= cx_next[2];
      c2_y <= cy_next[2];
      c3_x <= cx_next[3];
      c3_y <= cy_next[3];
    end
  end

`ifndef ASSERT_OFF
  // The input can only be held off while the first stage holds a sprite.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    sprite_stall |-> vld[0])
    else $error("input stalled with an empty first stage");

  // With nothing waiting at the output the pipeline must take a new sprite.
  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !quad_valid |-> !sprite_stall)
    else $error("input stalled while the output register is empty");

  // A full pipeline behind a stalled output must stall the input.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (&vld && quad_stall) |-> sprite_stall)
    else $error("input not stalled with every stage full and output stalled");
`endif

endmodule

[sim/sqct_corner_checker.sv]
// Corner checker for the sprite quad corner transform: watches both transfer
// channels, predicts the four screen corners of each sprite and compares them.
// Depends on sqct_pkg for the output limits and the default parameters.
module sqct_corner_checker #(
  parameter int ANGLE_W = sqct_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_W  = sqct_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sprite_valid,
  input  logic                sprite_stall,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [15:0]  pivot_x,
  input  logic signed [15:0]  pivot_y,
  input  logic        [15:0]  rect_w,
  input  logic        [15:0]  rect_h,
  input  logic [ANGLE_W-1:0]  angle,
  input  logic signed [15:0]  scale_h,
  input  logic signed [15:0]  scale_v,
  input  logic                quad_valid,
  input  logic                quad_stall,
  input  logic signed [23:0]  c0_x,
  input  logic signed [23:0]  c0_y,
  input  logic signed [23:0]  c1_x,
  input  logic signed [23:0]  c1_y,
  input  logic signed [23:0]  c2_x,
  input  logic signed [23:0]  c2_y,
  input  logic signed [23:0]  c3_x,
  input  logic signed [23:0]  c3_y,
  output int                  failures,
  output int                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QSTEPS = 1 << (ANGLE_W - 2);
  localparam int ROUND_SH = 12 + FRAC_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Element 2k is the x of corner k, element 2k+1 its y.
  typedef logic [7:0][23:0] corners_t;

  longint   sine_rom [0:QSTEPS];
  corners_t corner_q [$];
  corners_t got;
  corners_t want;
  int       fail_count;
  string    coord_name [8] = '{"c0_x", "c0_y", "c1_x", "c1_y",
                               "c2_x", "c2_y", "c3_x", "c3_y"};

  // Sine of i quarter-steps, Taylor series in Q2.30, rounded half up.
  function automatic longint quarter_sine(int unsigned i);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] up;
    bit [63:0] down;
    bit [63:0] s;
    x    = (64'(i) * HALF_PI_Q30) >> (ANGLE_W - 2);
    x2   = (x * x) >> 30;
    term = x;
    up   = x;
    down = '0;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        down = down + term;
      end else begin
        up = up + term;
      end
    end
    s = up - down;
    return longint'((s + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W));
  endfunction

  // Round the rotated offset half toward plus infinity, add, saturate.
  function automatic logic [23:0] place_coord(longint base, longint prod);
    longint v;
    v = base + ((prod + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH);
    if (v > longint'(sqct_pkg::OUT_MAX)) begin
      v = longint'(sqct_pkg::OUT_MAX);
    end
    if (v < longint'(sqct_pkg::OUT_MIN)) begin
      v = longint'(sqct_pkg::OUT_MIN);
    end
    return v[23:0];
  endfunction

  function automatic corners_t transform_sprite(
    input logic signed [15:0] px, py, cx, cy,
    input logic [15:0] w, h,
    input logic [ANGLE_W-1:0] ang,
    input logic signed [15:0] sh, sv
  );
    longint     hs;
    longint     vs;
    longint     ox [2];
    longint     oy [2];
    longint     sn;
    longint     cs;
    longint     dx;
    longint     dy;
    int         idx;
    logic [1:0] quad;
    corners_t   res;
    hs = sh;
    vs = (sv == 0) ? longint'(sh) : longint'(sv);
    ox[0] = -longint'(cx) * hs;
    ox[1] = (longint'(w) - longint'(cx)) * hs;
    oy[0] = -longint'(cy) * vs;
    oy[1] = (longint'(h) - longint'(cy)) * vs;
    quad = ang[ANGLE_W-1 -: 2];
    idx  = int'(ang[ANGLE_W-3:0]);
    case (quad)
      2'd0: begin
        sn = sine_rom[idx];
        cs = sine_rom[QSTEPS - idx];
      end
      2'd1: begin
        sn = sine_rom[QSTEPS - idx];
        cs = -sine_rom[idx];
      end
      2'd2: begin
        sn = -sine_rom[idx];
        cs = -sine_rom[QSTEPS - idx];
      end
      default: begin
        sn = -sine_rom[QSTEPS - idx];
        cs = sine_rom[idx];
      end
    endcase
    // Corners run top-left, top-right, bottom-right, bottom-left.
    for (int k = 0; k < 4; k++) begin
      dx = ox[(k == 1 || k == 2) ? 1 : 0];
      dy = oy[(k >= 2) ? 1 : 0];
      res[2*k]   = place_coord(longint'(px), dx * cs - dy * sn);
      res[2*k+1] = place_coord(longint'(py), dx * sn + dy * cs);
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    for (int i = 0; i <= QSTEPS; i++) begin
      sine_rom[i] = quarter_sine(i);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (quad_valid && !quad_stall) begin
        got = {c3_y, c3_x, c2_y, c2_x, c1_y, c1_x, c0_y, c0_x};
        if (corner_q.size() == 0) begin
          $display("%0t: quad transfer with no sprite outstanding, expected none, got %0d %0d %0d %0d %0d %0d %0d %0d",
                   $time, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y);
          fail_count++;
        end else begin
          want = corner_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got[k] !== want[k]) begin
              $display("%0t: %s mismatch, expected %0d, got %0d", $time, coord_name[k],
                       $signed(want[k]), $signed(got[k]));
              fail_count++;
            end
          end
        end
      end
      if (sprite_valid && !sprite_stall) begin
        corner_q.push_back(transform_sprite(pos_x, pos_y, pivot_x, pivot_y, rect_w,
                                            rect_h, angle, scale_h, scale_v));
      end
    end
    failures <= fail_count;
    pending  <= corner_q.size();
  end

endmodule

[sim/tb_sprite_quad_corner_transform_unit.sv]
// Testbench top for sprite_quad_corner_transform_unit: clock, reset, sprite
// stimulus, receiver stalls and the verdict. Depends on sqct_pkg, the unit
// and sqct_corner_checker, which does all prediction and comparison.
module tb_sprite_quad_corner_transform_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_W = sqct_pkg::ANGLE_BITS_DEF;
  localparam int FRAC_W  = sqct_pkg::TRIG_FRAC_BITS_DEF;

  // Length of the long receiver hold-off, in cycles. Much longer than the
  // five-stage pipeline so the unit fills completely and stalls its input.
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        pivot_x;
    logic [15:0]        pivot_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        scale_h;
    logic [15:0]        scale_v;
  } sprite_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       sprite_valid;
  logic                       sprite_stall;
  logic signed [15:0]         pos_x;
  logic signed [15:0]         pos_y;
  logic signed [15:0]         pivot_x;
  logic signed [15:0]         pivot_y;
  logic        [15:0]         rect_w;
  logic        [15:0]         rect_h;
  logic        [ANGLE_W-1:0]  angle;
  logic signed [15:0]         scale_h;
  logic signed [15:0]         scale_v;
  logic                       quad_valid;
  logic                       quad_stall;
  logic signed [23:0]         c0_x;
  logic signed [23:0]         c0_y;
  logic signed [23:0]         c1_x;
  logic signed [23:0]         c1_y;
  logic signed [23:0]         c2_x;
  logic signed [23:0]         c2_y;
  logic signed [23:0]         c3_x;
  logic signed [23:0]         c3_y;

  int failures;
  int pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  // The sender's figure is only used by the stimulus process; the receiver's
  // is updated with a nonblocking write so the stall process sees it cleanly.
  int idle_pct;
  int stall_pct;

  // Each increment asks the stall process for one long hold-off.
  int hold_count;

  always #10 clk = ~clk;

  sprite_quad_corner_transform_unit #(
    .ANGLE_BITS     (ANGLE_W),
    .TRIG_FRAC_BITS (FRAC_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sprite_valid (sprite_valid),
    .sprite_stall (sprite_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pivot_x      (pivot_x),
    .pivot_y      (pivot_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .angle        (angle),
    .scale_h      (scale_h),
    .scale_v      (scale_v),
    .quad_valid   (quad_valid),
    .quad_stall   (quad_stall),
    .c0_x         (c0_x),
    .c0_y         (c0_y),
    .c1_x         (c1_x),
    .c1_y         (c1_y),
    .c2_x         (c2_x),
    .c2_y         (c2_y),
    .c3_x         (c3_x),
    .c3_y         (c3_y)
  );

  sqct_corner_checker #(
    .ANGLE_W (ANGLE_W),
    .FRAC_W  (FRAC_W)
  ) corner_check (
    .clk          (clk),
    .rst          (rst),
    .sprite_valid (sprite_valid),
    .sprite_stall (sprite_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pivot_x      (pivot_x),
    .pivot_y      (pivot_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .angle        (angle),
    .scale_h      (scale_h),
    .scale_v      (scale_v),
    .quad_valid   (quad_valid),
    .quad_stall   (quad_stall),
    .c0_x         (c0_x),
    .c0_y         (c0_y),
    .c1_x         (c1_x),
    .c1_y         (c1_y),
    .c2_x         (c2_x),
    .c2_y         (c2_y),
    .c3_x         (c3_x),
    .c3_y         (c3_y),
    .failures     (failures),
    .pending      (pending)
  );

  function automatic sprite_t make_sprite(
    input logic [15:0] px, py, cx, cy, w, h,
    input logic [ANGLE_W-1:0] ang,
    input logic [15:0] sh, sv
  );
    sprite_t s;
    s.pos_x   = px;
    s.pos_y   = py;
    s.pivot_x = cx;
    s.pivot_y = cy;
    s.rect_w  = w;
    s.rect_h  = h;
    s.angle   = ang;
    s.scale_h = sh;
    s.scale_v = sv;
    return s;
  endfunction

  // A 16-bit field value: sometimes an extreme, often a moderate value around
  // zero within the given span, otherwise any pattern at all.
  function automatic logic [15:0] pick_field(int span);
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      1, 2, 3: return 16'($urandom_range(2 * span) - span);
      default: return 16'($urandom);
    endcase
  endfunction

  // Scales cluster around plus and minus one half the time; otherwise they are
  // drawn like any other field, full-range values included.
  function automatic logic [15:0] pick_scale();
    case ($urandom_range(3))
      0:       return 16'(16'sh1000 + $urandom_range(1024) - 512);
      1:       return 16'(-16'sh1000 + $urandom_range(1024) - 512);
      default: return pick_field(16384);
    endcase
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.pos_x   = pick_field(8000);
    s.pos_y   = pick_field(8000);
    s.pivot_x = pick_field(2000);
    s.pivot_y = pick_field(2000);
    s.rect_w  = pick_field(2000);
    s.rect_h  = pick_field(2000);
    // Quadrant boundaries and their neighbors get extra weight.
    if ($urandom_range(7) == 0) begin
      s.angle = ANGLE_W'($urandom_range(3) << (ANGLE_W - 2)) +
                ANGLE_W'($urandom_range(2)) - ANGLE_W'(1);
    end else begin
      s.angle = ANGLE_W'($urandom);
    end
    s.scale_h = pick_scale();
    // A zero vertical scale borrows the horizontal one.
    s.scale_v = ($urandom_range(4) == 0) ? 16'h0000 : pick_scale();
    return s;
  endfunction

  // Offer one sprite, after a random idle gap, and hold it until the unit
  // takes the transfer. Valid is set once per sprite and never looks at stall.
  task automatic send_sprite(input sprite_t s);
    while ($urandom_range(99) < idle_pct) begin
      sprite_valid <= 1'b0;
      @(posedge clk);
    end
    pos_x        <= s.pos_x;
    pos_y        <= s.pos_y;
    pivot_x      <= s.pivot_x;
    pivot_y      <= s.pivot_y;
    rect_w       <= s.rect_w;
    rect_h       <= s.rect_h;
    angle        <= s.angle;
    scale_h      <= s.scale_h;
    scale_v      <= s.scale_v;
    sprite_valid <= 1'b1;
    @(posedge clk);
    while (sprite_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(int count, int send_idle, int recv_stall);
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    repeat (count) begin
      send_sprite(random_sprite());
    end
  endtask

  // Receiver side. Normally it stalls at random at the current rate; when a
  // hold-off is requested it keeps the output stalled for the long hold-off,
  // counted here, while the sender keeps offering sprites.
  initial begin
    int hold_seen;
    hold_seen  = 0;
    quad_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_count != hold_seen) begin
        hold_seen = hold_count;
        quad_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        quad_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    sprite_valid = 1'b0;
    pos_x        = '0;
    pos_y        = '0;
    pivot_x      = '0;
    pivot_y      = '0;
    rect_w       = '0;
    rect_h       = '0;
    angle        = '0;
    scale_h      = '0;
    scale_v      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_count   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed sprites. A 32x16 pixel rectangle pivoting on its center at
    // unit scale is walked through the quadrant boundaries, the smallest and
    // largest angles and the half-quadrant point.
    send_sprite(make_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 12'h000, 16'h0000, 16'h0000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h000, 16'h1000, 16'h0000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h400, 16'h1000, 16'h1000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h800, 16'h1000, 16'h1000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'hC00, 16'h1000, 16'h1000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'hFFF, 16'h1000, 16'h1000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h001, 16'h1000, 16'h1000));
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h200, 16'h1000, 16'h1000));
    // Different scales per axis, then both scales zero (every corner sits on
    // the position), then only the horizontal scale zero.
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h155, 16'h2000, 16'h0800));
    send_sprite(make_sprite(16'h1234, 16'hEDCB, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h321, 16'h0000, 16'h0000));
    send_sprite(make_sprite(16'h1234, 16'hEDCB, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'h0AB, 16'h0000, 16'h1000));
    // Extreme positions, pivots, rectangles and scales.
    send_sprite(make_sprite(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
                            16'hFFFF, 12'h000, 16'h7FFF, 16'h7FFF));
    send_sprite(make_sprite(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000,
                            16'h0000, 12'h000, 16'h7FFF, 16'h7FFF));
    send_sprite(make_sprite(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
                            16'hFFFF, 12'h800, 16'h8000, 16'h8000));
    send_sprite(make_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                            16'hFFFF, 12'h200, 16'h7FFF, 16'h8000));
    // Negative unit scale, the smallest scale steps and small rectangles.
    send_sprite(make_sprite(16'h0640, 16'h0320, 16'h0100, 16'h0080, 16'h0200,
                            16'h0100, 12'hC00, 16'hF000, 16'h0000));
    send_sprite(make_sprite(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001,
                            16'h0001, 12'h3FF, 16'h0001, 16'hFFFF));
    send_sprite(make_sprite(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                            16'h0001, 12'h7FF, 16'h0001, 16'h0001));
    // Alternating bit patterns so every input bit toggles early on.
    send_sprite(make_sprite(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                            16'h5555, 12'hAAA, 16'h5555, 16'h5555));
    send_sprite(make_sprite(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                            16'hAAAA, 12'h555, 16'hAAAA, 16'hAAAA));

    // Random sprites: back-to-back traffic, a starved input, a congested
    // output, and light idling on both sides.
    run_phase(450, 0, 0);
    run_phase(450, 65, 0);
    run_phase(450, 0, 65);
    run_phase(450, 20, 20);

    // Long output hold-off while sprites keep coming: the pipeline fills,
    // the input stalls, and then everything drains at full rate.
    hold_count <= hold_count + 1;
    run_phase(100, 0, 0);

    sprite_valid <= 1'b0;
    stall_pct <= 0;
    while (pending != 0) begin
      @(posedge clk);
    end
    // Keep the clock running after the checker is empty, so any stray extra transfer is caught.
    repeat (20) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("sprite_quad_corner_transform_unit test passed");
    end else begin
      $display("sprite_quad_corner_transform_unit test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legitimate run.
  initial begin
    #5_000_000;
    $display("sprite_quad_corner_transform_unit test failed");
    $finish;
  end

endmodule

[files.f]
sv/sqct_pkg.sv
sv/sqct_sin_rom.sv
sv/sqct_offset.sv
sv/sqct_rotate.sv
sv/sprite_quad_corner_transform_unit.sv
sim/sqct_corner_checker.sv
sim/tb_sprite_quad_corner_transform_unit.sv
